// File: rtl/core/wrms_pkg.sv
// Package for the windowed RMS block: sizes, register codes and shared types.
// Used by every module under rtl/core; depends on nothing else.

package wrms_pkg;

  // Field and datapath sizes.
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 4096;
  localparam int LEN_BITS    = 13;
  localparam int SQUARE_BITS = 2 * SAMPLE_BITS;
  localparam int SUM_BITS    = 43;
  localparam int RMS_BITS    = 16;
  localparam int ROOT_IN_BITS = 2 * RMS_BITS;
  localparam int SQ_REM_BITS = RMS_BITS + 4;

  // Back-end iteration counts: one quotient bit, or one root bit, per cycle.
  localparam int DIV_STEPS  = SUM_BITS;
  localparam int SQRT_STEPS = RMS_BITS;
  localparam int STEP_BITS  = 6;

  // Window queue between the accumulator and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QLVL_BITS   = 3;

  // Configuration port.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic [LEN_BITS-1:0] WINDOW_RESET = 13'd1024;

  // One input transaction.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } sample_t;

  // One result transaction.
  typedef struct packed {
    logic [RMS_BITS-1:0] rms;
    logic [LEN_BITS-1:0] window_count;
    logic                stream_end;
  } result_t;

  // A closed window waiting for the divide and root.
  typedef struct packed {
    logic [SUM_BITS-1:0] square_sum;
    logic [LEN_BITS-1:0] sample_count;
    logic                stream_end;
  } window_t;

  // Queue status seen by the front and the back end.
  typedef struct packed {
    logic                 head_valid;
    logic [QLVL_BITS-1:0] level;
  } queue_status_t;

  // Back-end sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

  // Back-end control strobes.
  typedef struct packed {
    logic pop;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } back_ctrl_t;

endpackage

// File: rtl/core/wrms_front.sv
// Front end of the windowed RMS block: squares samples, accumulates, closes windows.
// Depends on wrms_pkg; pushes closed windows into wrms_queue.

module wrms_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  wrms_pkg::sample_t               sample_item,
  input  logic [wrms_pkg::LEN_BITS-1:0]   window_length,
  input  wrms_pkg::queue_status_t         qstat,
  output logic                            push,
  output wrms_pkg::window_t               push_win
);
  import wrms_pkg::*;

  logic                    take;
  logic [SAMPLE_BITS-1:0]  raw;
  logic [SAMPLE_BITS-1:0]  mag;
  logic [SQUARE_BITS-1:0]  square;
  logic                    s1_valid;
  logic [SQUARE_BITS-1:0]  s1_square;
  logic                    s1_last;
  logic [SUM_BITS-1:0]     square_sum;
  logic [SUM_BITS-1:0]     square_sum_next;
  logic [LEN_BITS-1:0]     sample_count;
  logic [LEN_BITS-1:0]     sample_count_next;
  logic [LEN_BITS-1:0]     eff_len;
  logic                    close;

  // Accept only while the queue can take any window that is still in flight.
  assign sample_ready = ({1'b0, qstat.level} + {{QLVL_BITS{1'b0}}, s1_valid})
                        < (QLVL_BITS + 1)'(QUEUE_DEPTH);
  assign take = sample_valid && sample_ready;

  // Magnitude of the two's complement sample, then its square.
  assign raw    = sample_item.sample;
  assign mag    = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  assign square = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

  // Square stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    if (take) begin
      s1_square <= square;
      s1_last   <= sample_item.last_sample;
    end
  end

  // Window length as used: zero means one, large values saturate.
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (window_length > LEN_BITS'(MAX_WINDOW)) begin
      eff_len = LEN_BITS'(MAX_WINDOW);
    end else begin
      eff_len = window_length;
    end
  end

  // Accumulate and decide whether this sample closes the window.
  assign square_sum_next   = square_sum + {{(SUM_BITS-SQUARE_BITS){1'b0}}, s1_square};
  assign sample_count_next = sample_count + LEN_BITS'(1);
  assign close = s1_valid && ((sample_count_next >= eff_len) || s1_last);

  assign push                  = close;
  assign push_win.square_sum   = square_sum_next;
  assign push_win.sample_count = sample_count_next;
  assign push_win.stream_end   = s1_last;

  // Accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (close) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (s1_valid) begin
      square_sum   <= square_sum_next;
      sample_count <= sample_count_next;
    end
  end

endmodule

// File: rtl/core/wrms_queue.sv
// Short queue of closed windows between the front end and the back end.
// Depends on wrms_pkg.

module wrms_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  wrms_pkg::window_t       push_win,
  input  logic                    pop,
  output wrms_pkg::window_t       head_win,
  output wrms_pkg::queue_status_t qstat
);
  import wrms_pkg::*;

  window_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QLVL_BITS-1:0] level;

  assign head_win         = entries[rd_ptr];
  assign qstat.head_valid = (level != '0);
  assign qstat.level      = level;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_win;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + QLVL_BITS'(1);
        2'b01:   level <= level - QLVL_BITS'(1);
        default: level <= level;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < QLVL_BITS'(QUEUE_DEPTH)))
    else $error("window queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("window queue read while empty");

  a_level_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (level == $past(level) + QLVL_BITS'(1)))
    else $error("window queue level did not follow a push");
`endif

endmodule

// File: rtl/core/wrms_back.sv
// Back end of the windowed RMS block: divides the window sum by its count,
// takes the floor square root and holds the result transaction. Depends on wrms_pkg.

module wrms_back (
  input  logic                    clk,
  input  logic                    rst,
  input  wrms_pkg::queue_status_t qstat,
  input  wrms_pkg::window_t       head_win,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_ready,
  output wrms_pkg::result_t       result_item
);
  import wrms_pkg::*;

  localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(DIV_STEPS - 1);
  localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(SQRT_STEPS - 1);

  back_state_t          state;
  back_state_t          state_next;
  back_ctrl_t           ctrl;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]  dq;
  logic [SUM_BITS-1:0]  dq_next;
  logic [LEN_BITS-1:0]  div_rem;
  logic [LEN_BITS-1:0]  div_rem_next;
  logic [LEN_BITS-1:0]  divisor;
  logic                 last_flag;
  logic [LEN_BITS:0]    div_trial;
  logic                 div_ge;
  logic [SQ_REM_BITS-1:0] sq_rem;
  logic [SQ_REM_BITS-1:0] sq_rem_next;
  logic [SQ_REM_BITS-1:0] sq_shift;
  logic [SQ_REM_BITS-1:0] sq_trial;
  logic                   sq_ge;
  logic [RMS_BITS-1:0]    root;
  logic                   out_free;

  assign out_free = !result_valid || result_ready;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (qstat.head_valid) state_next = BK_DIV;
      BK_DIV:  if (step == DIV_LAST) state_next = BK_SQRT;
      BK_SQRT: if (step == SQRT_LAST) state_next = BK_DONE;
      BK_DONE: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl = '0;
    unique case (state)
      BK_IDLE: ctrl.pop = qstat.head_valid;
      BK_DIV:  ctrl.div_step = 1'b1;
      BK_SQRT: ctrl.sqrt_step = 1'b1;
      BK_DONE: ctrl.out_load = out_free;
      default: ctrl = '0;
    endcase
  end

  assign pop = ctrl.pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring division step: one quotient bit enters dq each cycle.
  assign div_trial    = {div_rem, dq[SUM_BITS-1]};
  assign div_ge       = (div_trial >= {1'b0, divisor});
  assign div_rem_next = div_ge ? LEN_BITS'(div_trial - {1'b0, divisor})
                               : div_trial[LEN_BITS-1:0];

  // Root step: two bits of the mean enter the remainder each cycle.
  assign sq_shift    = {sq_rem[SQ_REM_BITS-3:0], dq[ROOT_IN_BITS-1 -: 2]};
  assign sq_trial    = {{(SQ_REM_BITS-RMS_BITS-2){1'b0}}, root, 2'b01};
  assign sq_ge       = (sq_shift >= sq_trial);
  assign sq_rem_next = sq_ge ? (sq_shift - sq_trial) : sq_shift;

  // The quotient and the root input share the dq shift register.
  always_comb begin
    dq_next = dq;
    if (ctrl.div_step) begin
      dq_next = {dq[SUM_BITS-2:0], div_ge};
    end else if (ctrl.sqrt_step) begin
      dq_next = {dq[SUM_BITS-1:ROOT_IN_BITS], dq[ROOT_IN_BITS-3:0], 2'b00};
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (ctrl.pop || (ctrl.div_step && (step == DIV_LAST))) begin
      step <= '0;
    end else if (ctrl.div_step || ctrl.sqrt_step) begin
      step <= step + STEP_BITS'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      dq        <= head_win.square_sum;
      divisor   <= head_win.sample_count;
      last_flag <= head_win.stream_end;
      div_rem   <= '0;
      sq_rem    <= '0;
      root      <= '0;
    end else begin
      dq <= dq_next;
      if (ctrl.div_step) begin
        div_rem <= div_rem_next;
      end
      if (ctrl.sqrt_step) begin
        sq_rem <= sq_rem_next;
        root   <= {root[RMS_BITS-2:0], sq_ge};
      end
    end
  end

  // Result register: holds a finished transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (ctrl.out_load) begin
      result_item.rms          <= root;
      result_item.window_count <= divisor;
      result_item.stream_end   <= last_flag;
    end
  end

`ifndef SYNTHESIS
  a_pop_has_window: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> qstat.head_valid)
    else $error("back end took a window from an empty queue");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV && step == DIV_LAST) |=> (div_rem < divisor))
    else $error("division remainder not below the divisor");

  a_mean_fits_root: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SQRT) |-> (dq[SUM_BITS-1:ROOT_IN_BITS] == '0))
    else $error("mean of squares wider than the root input");
`endif

endmodule

// File: rtl/core/windowed_rms_top.sv
// Windowed RMS: one sample transaction per cycle while sample_ready is high; a closing
// sample is squared, accumulated, queued, divided and rooted into a result transaction.
// The divider and root unit handle one window at a time; a queue of four windows
// lets accumulation go on meanwhile, so short windows can throttle samples.
// Reset (rst, synchronous) empties the window, the queue and the result register,
// and sets window_length to 1024.

module windowed_rms_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  wrms_pkg::sample_t                sample_item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output wrms_pkg::result_t                result_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wrms_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [wrms_pkg::DATA_BITS-1:0]   pwdata,
  output logic [wrms_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);
  import wrms_pkg::*;

  logic [LEN_BITS-1:0] window_length;
  logic                reg_hit;
  logic                push;
  window_t             push_win;
  window_t             head_win;
  queue_status_t       qstat;
  logic                pop;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_BITS-1] == REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      window_length <= pwdata[LEN_BITS-1:0];
    end
  end

  assign prdata = reg_hit ? {{(DATA_BITS-LEN_BITS){1'b0}}, window_length} : '0;

  // Accumulator front end.
  wrms_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample_item   (sample_item),
    .window_length (window_length),
    .qstat         (qstat),
    .push          (push),
    .push_win      (push_win)
  );

  // Closed windows waiting for the back end.
  wrms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_win (push_win),
    .pop      (pop),
    .head_win (head_win),
    .qstat    (qstat)
  );

  // Divide, root and result register.
  wrms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head_win     (head_win),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
